>>> hw/rtl/uhcr_pkg.sv
// shared types, constants and register word offsets of the usb host controller register block
package uhcr_pkg;

  // root hub ports, 1 to 15
  localparam int NUM_PORTS = 3;
  localparam int PORT_IW   = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  localparam logic [31:0] REVISION       = 32'h0000_0110;
  localparam logic [31:0] FMI_RESET      = 32'h0000_2edf;
  localparam logic [31:0] LSTH_HCR       = 32'h0000_0628;
  localparam logic [31:0] IEN_MASK       = 32'hc000_007f;
  // pending sources that drive the line: 0x4000007f without sof
  localparam logic [31:0] IRQ_MASK       = 32'h4000_007b;
  localparam logic [31:0] FRAME_REM_MASK = 32'h0000_3fff;
  localparam logic [31:0] RHA_RESET      = 32'h0100_0000 | 32'(NUM_PORTS);
  localparam logic [10:0] CTRL_KEEP_HCR  = 11'h300;
  localparam logic [10:0] CTRL_SET_HCR   = 11'h0c0;
  localparam logic [1:0]  FS_OPERATIONAL = 2'b10;

  // word offsets (byte offset / 4)
  localparam logic [6:0] W_REV    = 7'd0;
  localparam logic [6:0] W_CTRL   = 7'd1;
  localparam logic [6:0] W_CMD    = 7'd2;
  localparam logic [6:0] W_ISTAT  = 7'd3;
  localparam logic [6:0] W_IEN    = 7'd4;
  localparam logic [6:0] W_IDIS   = 7'd5;
  localparam logic [6:0] W_HCCA   = 7'd6;
  localparam logic [6:0] W_ED0    = 7'd7;
  localparam logic [6:0] W_ED4    = 7'd11;
  localparam logic [6:0] W_DONE   = 7'd12;
  localparam logic [6:0] W_FMI    = 7'd13;
  localparam logic [6:0] W_FMR    = 7'd14;
  localparam logic [6:0] W_FMN    = 7'd15;
  localparam logic [6:0] W_PSTART = 7'd16;
  localparam logic [6:0] W_LSTH   = 7'd17;
  localparam logic [6:0] W_RHA    = 7'd18;
  localparam logic [6:0] W_RHB    = 7'd19;
  localparam logic [6:0] W_RHS    = 7'd20;
  localparam logic [6:0] W_PORT0  = 7'd21;
  localparam logic [4:0] W_LEG_HI = 5'b10000;

  localparam int ED_DEPTH  = 5;
  localparam int LEG_DEPTH = 4;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [4:0] {
    SEL_NONE,
    SEL_REV,
    SEL_CTRL,
    SEL_CMD,
    SEL_ISTAT,
    SEL_IEN,
    SEL_IDIS,
    SEL_HCCA,
    SEL_ED,
    SEL_DONE,
    SEL_FMI,
    SEL_FMR,
    SEL_FMN,
    SEL_PSTART,
    SEL_LSTH,
    SEL_RHA,
    SEL_RHB,
    SEL_RHS,
    SEL_PORT,
    SEL_LEG
  } reg_sel_t;

  typedef struct packed {
    logic               rd;
    logic               wr;
    logic               tick;
    reg_sel_t           sel;
    logic [PORT_IW-1:0] port_idx;
    logic [2:0]         ed_idx;
    logic [1:0]         leg_idx;
    logic [31:0]        wdata;
  } item_t;

endpackage

>>> hw/rtl/usb_host_controller_registers.sv
// top level of the usb host controller register block with result register and checks
//
// usage:
// - one command channel: an item (operation, bar, address, write_data) is taken
//   at a rising edge with start high and busy low; busy is always low, so an
//   item can be issued in every cycle
// - operations: register read, register write, one millisecond frame tick,
//   counted on any bar; bars other than 0 read 0 and write nothing
// - every item gives one result: out_valid is high for exactly one cycle with
//   out_read_data (read value, 0 otherwise) and out_irq_level (interrupt line
//   after the item)
// - an accepted item is held in the decode register and then in the result
//   register; throughput is one item per cycle, set by the single
//   decode register to result register pass
// - results cannot be held off: the receiver takes each one in its strobe cycle
// - synchronous reset (rst_n low) loads register defaults and drops any item
//   in flight; no clearing pass is needed
module usb_host_controller_registers (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [2:0]  in_bar,
  input  logic [8:0]  in_address,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  output logic [31:0] out_read_data,
  output logic        out_irq_level
);

  logic            accept;
  logic            item_valid;
  uhcr_pkg::item_t item;
  logic [31:0]     rdata;
  logic            irq_level;

  logic            out_valid_r;
  logic [31:0]     out_read_data_r;

  // every access finishes in one pass, so the block never pushes back
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: capture and decode the item
  uhcr_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_operation  (in_operation),
    .in_bar        (in_bar),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .item_valid_r  (item_valid),
    .item_r        (item)
  );

  // stage 2: register access, side effects and interrupt update
  uhcr_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .rdata      (rdata),
    .irq_level  (irq_level)
  );

  // result register; the interrupt line is already a register in the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= item_valid;
    end
    out_read_data_r <= rdata;
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_irq_level = irq_level;

  // a result always traces back to an accepted item, through the decode and result registers
  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(accept, 2))
    else $error("result strobe without an accepted item");

  // non-zero read data only comes from a bar 0 read
  a_rdata_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_read_data != 32'd0) |-> $past(item_valid && item.rd))
    else $error("read data without a read");

  // the interrupt line moves only on a register write
  a_irq_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(item_valid && item.wr)) |-> $stable(out_irq_level))
    else $error("interrupt line changed without a write");

endmodule

>>> hw/rtl/uhcr_decode.sv
// input register with address decode of the accepted item
module uhcr_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [1:0]           in_operation,
  input  logic [2:0]           in_bar,
  input  logic [8:0]           in_address,
  input  logic [31:0]          in_write_data,
  output logic                 item_valid_r,
  output uhcr_pkg::item_t      item_r
);

  logic [6:0]           word;
  logic [6:0]           port_off;
  logic [6:0]           ed_off;
  logic                 aligned;
  logic                 bar0;
  uhcr_pkg::item_t      item_nxt;

  assign word     = in_address[8:2];
  assign aligned  = (in_address[1:0] == 2'b00);
  assign bar0     = (in_bar == 3'd0);
  assign port_off = word - uhcr_pkg::W_PORT0;
  assign ed_off   = word - uhcr_pkg::W_ED0;

  always_comb begin
    item_nxt          = '0;
    item_nxt.rd       = (in_operation == uhcr_pkg::OP_READ) && bar0;
    item_nxt.wr       = (in_operation == uhcr_pkg::OP_WRITE) && bar0;
    item_nxt.tick     = (in_operation == uhcr_pkg::OP_TICK);
    item_nxt.port_idx = port_off[uhcr_pkg::PORT_IW-1:0];
    item_nxt.ed_idx   = ed_off[2:0];
    item_nxt.leg_idx  = word[1:0];
    item_nxt.wdata    = in_write_data;
    item_nxt.sel      = uhcr_pkg::SEL_NONE;
    priority if (!aligned) begin
      item_nxt.sel = uhcr_pkg::SEL_NONE;
    end else if (word >= uhcr_pkg::W_PORT0 && port_off < 7'(uhcr_pkg::NUM_PORTS)) begin
      item_nxt.sel = uhcr_pkg::SEL_PORT;
    end else if (word >= uhcr_pkg::W_ED0 && word <= uhcr_pkg::W_ED4) begin
      item_nxt.sel = uhcr_pkg::SEL_ED;
    end else if (word[6:2] == uhcr_pkg::W_LEG_HI) begin
      item_nxt.sel = uhcr_pkg::SEL_LEG;
    end else begin
      unique case (word)
        uhcr_pkg::W_REV:    item_nxt.sel = uhcr_pkg::SEL_REV;
        uhcr_pkg::W_CTRL:   item_nxt.sel = uhcr_pkg::SEL_CTRL;
        uhcr_pkg::W_CMD:    item_nxt.sel = uhcr_pkg::SEL_CMD;
        uhcr_pkg::W_ISTAT:  item_nxt.sel = uhcr_pkg::SEL_ISTAT;
        uhcr_pkg::W_IEN:    item_nxt.sel = uhcr_pkg::SEL_IEN;
        uhcr_pkg::W_IDIS:   item_nxt.sel = uhcr_pkg::SEL_IDIS;
        uhcr_pkg::W_HCCA:   item_nxt.sel = uhcr_pkg::SEL_HCCA;
        uhcr_pkg::W_DONE:   item_nxt.sel = uhcr_pkg::SEL_DONE;
        uhcr_pkg::W_FMI:    item_nxt.sel = uhcr_pkg::SEL_FMI;
        uhcr_pkg::W_FMR:    item_nxt.sel = uhcr_pkg::SEL_FMR;
        uhcr_pkg::W_FMN:    item_nxt.sel = uhcr_pkg::SEL_FMN;
        uhcr_pkg::W_PSTART: item_nxt.sel = uhcr_pkg::SEL_PSTART;
        uhcr_pkg::W_LSTH:   item_nxt.sel = uhcr_pkg::SEL_LSTH;
        uhcr_pkg::W_RHA:    item_nxt.sel = uhcr_pkg::SEL_RHA;
        uhcr_pkg::W_RHB:    item_nxt.sel = uhcr_pkg::SEL_RHB;
        uhcr_pkg::W_RHS:    item_nxt.sel = uhcr_pkg::SEL_RHS;
        default:            item_nxt.sel = uhcr_pkg::SEL_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= accept;
    end
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

>>> hw/rtl/uhcr_regs.sv
// controller register state, write side effects, read mux and interrupt line
module uhcr_regs (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  input  uhcr_pkg::item_t item,
  output logic [31:0]     rdata,
  output logic            irq_level
);

  logic [10:0] ctrl_r,   ctrl_nxt;
  logic [1:0]  cmd_r,    cmd_nxt;
  logic [31:0] istat_r,  istat_nxt;
  logic [31:0] ien_r,    ien_nxt;
  logic [22:0] hcca_r,   hcca_nxt;
  logic [27:0] ed_r     [uhcr_pkg::ED_DEPTH];
  logic [27:0] ed_nxt   [uhcr_pkg::ED_DEPTH];
  logic [31:0] fmi_r,    fmi_nxt;
  logic [31:0] pstart_r, pstart_nxt;
  logic [31:0] lsth_r,   lsth_nxt;
  logic [31:0] rha_r,    rha_nxt;
  logic [31:0] rhb_r,    rhb_nxt;
  logic        rwe_r,    rwe_nxt;
  logic        port_r   [uhcr_pkg::NUM_PORTS];
  logic        port_nxt [uhcr_pkg::NUM_PORTS];
  logic [31:0] leg_r    [uhcr_pkg::LEG_DEPTH];
  logic [31:0] leg_nxt  [uhcr_pkg::LEG_DEPTH];
  logic [15:0] ms_r,     ms_nxt;
  logic        irq_r,    irq_nxt;

  logic        wr;
  logic        oper;
  logic [31:0] d;

  assign wr   = item_valid && item.wr;
  assign d    = item.wdata;
  assign oper = (ctrl_r[7:6] == uhcr_pkg::FS_OPERATIONAL);

  always_comb begin
    ctrl_nxt   = ctrl_r;
    cmd_nxt    = cmd_r;
    istat_nxt  = istat_r;
    ien_nxt    = ien_r;
    hcca_nxt   = hcca_r;
    ed_nxt     = ed_r;
    fmi_nxt    = fmi_r;
    pstart_nxt = pstart_r;
    lsth_nxt   = lsth_r;
    rha_nxt    = rha_r;
    rhb_nxt    = rhb_r;
    rwe_nxt    = rwe_r;
    port_nxt   = port_r;
    leg_nxt    = leg_r;
    ms_nxt     = ms_r;
    irq_nxt    = irq_r;

    if (item_valid && item.tick) begin
      ms_nxt = ms_r + 16'd1;
    end

    if (wr) begin
      unique case (item.sel)
        uhcr_pkg::SEL_CTRL: ctrl_nxt = d[10:0];
        uhcr_pkg::SEL_CMD: begin
          // host controller reset first, then ownership change, then clf/blf
          if (d[0]) begin
            cmd_nxt    = 2'b00;
            istat_nxt  = '0;
            ien_nxt    = '0;
            hcca_nxt   = '0;
            for (int i = 0; i < uhcr_pkg::ED_DEPTH; i++) begin
              ed_nxt[i] = '0;
            end
            fmi_nxt    = uhcr_pkg::FMI_RESET;
            pstart_nxt = '0;
            lsth_nxt   = uhcr_pkg::LSTH_HCR;
            ctrl_nxt   = (ctrl_r & uhcr_pkg::CTRL_KEEP_HCR) | uhcr_pkg::CTRL_SET_HCR;
          end
          if (d[3]) begin
            ctrl_nxt[8]   = 1'b0;
            istat_nxt[30] = 1'b1;
          end
          cmd_nxt = cmd_nxt | d[2:1];
        end
        uhcr_pkg::SEL_ISTAT:  istat_nxt = istat_r & ~d;
        uhcr_pkg::SEL_IEN:    ien_nxt = ien_r | (d & uhcr_pkg::IEN_MASK);
        uhcr_pkg::SEL_IDIS:   ien_nxt = ien_r & ~(d & uhcr_pkg::IEN_MASK);
        uhcr_pkg::SEL_HCCA:   hcca_nxt = d[31:9];
        uhcr_pkg::SEL_ED:     ed_nxt[item.ed_idx] = d[31:4];
        uhcr_pkg::SEL_FMI:    fmi_nxt = d;
        uhcr_pkg::SEL_PSTART: pstart_nxt = d;
        uhcr_pkg::SEL_LSTH:   lsth_nxt = d;
        uhcr_pkg::SEL_RHA:    rha_nxt = d;
        uhcr_pkg::SEL_RHB:    rhb_nxt = d;
        uhcr_pkg::SEL_RHS:    rwe_nxt = d[15];
        uhcr_pkg::SEL_PORT: begin
          // clear wins when both set and clear bits are written
          if (d[8]) begin
            port_nxt[item.port_idx] = 1'b1;
          end
          if (d[9]) begin
            port_nxt[item.port_idx] = 1'b0;
          end
        end
        uhcr_pkg::SEL_LEG:    leg_nxt[item.leg_idx] = d;
        default: ;
      endcase
      irq_nxt = ien_nxt[31] && ((istat_nxt & ien_nxt & uhcr_pkg::IRQ_MASK) != '0);
    end
  end

  always_comb begin
    rdata = '0;
    if (item_valid && item.rd) begin
      unique case (item.sel)
        uhcr_pkg::SEL_REV:    rdata = uhcr_pkg::REVISION;
        uhcr_pkg::SEL_CTRL:   rdata = {21'b0, ctrl_r};
        uhcr_pkg::SEL_CMD:    rdata = {29'b0, cmd_r, 1'b0};
        uhcr_pkg::SEL_ISTAT:  rdata = istat_r | {29'b0, oper, 2'b0};
        uhcr_pkg::SEL_IEN,
        uhcr_pkg::SEL_IDIS:   rdata = ien_r;
        uhcr_pkg::SEL_HCCA:   rdata = {hcca_r, 9'b0};
        uhcr_pkg::SEL_ED:     rdata = {ed_r[item.ed_idx], 4'b0};
        uhcr_pkg::SEL_FMI:    rdata = fmi_r;
        uhcr_pkg::SEL_FMR:    rdata = fmi_r & uhcr_pkg::FRAME_REM_MASK;
        uhcr_pkg::SEL_FMN:    rdata = oper ? {16'b0, ms_r} : '0;
        uhcr_pkg::SEL_PSTART: rdata = pstart_r;
        uhcr_pkg::SEL_LSTH:   rdata = lsth_r;
        uhcr_pkg::SEL_RHA:    rdata = rha_r;
        uhcr_pkg::SEL_RHB:    rdata = rhb_r;
        uhcr_pkg::SEL_RHS:    rdata = {16'b0, rwe_r, 15'b0};
        uhcr_pkg::SEL_PORT:   rdata = {23'b0, port_r[item.port_idx], 8'b0};
        uhcr_pkg::SEL_LEG:    rdata = leg_r[item.leg_idx];
        default:              rdata = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r   <= '0;
      cmd_r    <= '0;
      istat_r  <= '0;
      ien_r    <= '0;
      hcca_r   <= '0;
      for (int i = 0; i < uhcr_pkg::ED_DEPTH; i++) begin
        ed_r[i] <= '0;
      end
      fmi_r    <= uhcr_pkg::FMI_RESET;
      pstart_r <= '0;
      lsth_r   <= '0;
      rha_r    <= uhcr_pkg::RHA_RESET;
      rhb_r    <= '0;
      rwe_r    <= 1'b0;
      for (int i = 0; i < uhcr_pkg::NUM_PORTS; i++) begin
        port_r[i] <= 1'b0;
      end
      for (int i = 0; i < uhcr_pkg::LEG_DEPTH; i++) begin
        leg_r[i] <= '0;
      end
      ms_r     <= '0;
      irq_r    <= 1'b0;
    end else begin
      ctrl_r   <= ctrl_nxt;
      cmd_r    <= cmd_nxt;
      istat_r  <= istat_nxt;
      ien_r    <= ien_nxt;
      hcca_r   <= hcca_nxt;
      ed_r     <= ed_nxt;
      fmi_r    <= fmi_nxt;
      pstart_r <= pstart_nxt;
      lsth_r   <= lsth_nxt;
      rha_r    <= rha_nxt;
      rhb_r    <= rhb_nxt;
      rwe_r    <= rwe_nxt;
      port_r   <= port_nxt;
      leg_r    <= leg_nxt;
      ms_r     <= ms_nxt;
      irq_r    <= irq_nxt;
    end
  end

  assign irq_level = irq_r;

endmodule
